// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
// Depends on nothing; pulled in by `include in the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STDI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted table check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STDI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted table check failed");

`endif

// ----- hw/rtl/stdi_pkg.sv -----
// Package for the sorted table dedup/insert unit: transaction types,
// sequencer states and default sizes. Depends on nothing.
package stdi_pkg;

   // Default sizes of the record table
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int NAME_BITS_DEF   = 16;

   // Use count saturates here
   localparam logic [15:0] USE_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] name_id;
      logic [31:0] mod_time;
      logic [31:0] file_size;
   } req_type;

   typedef struct packed {
      logic [7:0]  entry_position;
      logic        was_inserted;
      logic        table_full;
      logic [8:0]  entry_count;
      logic [15:0] use_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SEARCH_CMP,
      ST_SCAN,
      ST_SCAN_CMP,
      ST_PLACE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FINISH
   } state_type;

endpackage

// ----- hw/rtl/sorted_table_dedup_insert_unit.sv -----
// Sorted record table with duplicate detection and in-order insertion.
// Depends on stdi_pkg.
//
// One request is worked at a time through a single-port record memory with a
// registered read, so every record visit is a read followed by a compare. A
// request runs a binary search over the n held records, then scans the records
// of the same name, and on an insert moves each record above its position up
// one place by a read and a write. req_ready is high only while the sequencer
// is idle. A finished result sits in the output register while the next
// request is already accepted. The record memory is not cleared after reset;
// only positions below the record count are ever read, so no clearing pass is
// needed and requests are taken at once.
module sorted_table_dedup_insert_unit
   import stdi_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int NAME_BITS   = NAME_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW      = $clog2(TABLE_DEPTH + 1);
   localparam int IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int USE_LSB = 0;
   localparam int SIZ_LSB = 16;
   localparam int TIM_LSB = 48;
   localparam int NAM_LSB = 80;
   localparam int REC_W   = NAM_LSB + NAME_BITS;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

   // Record memory
   logic [REC_W-1:0] rec_mem [TABLE_DEPTH];
   logic [REC_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   logic [REC_W-1:0] mem_wdata;
   logic             mem_re;
   logic [IW-1:0]    mem_raddr;

   // Sequencer and datapath registers
   state_type state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        shift_ff, shift_in;
   logic [NAME_BITS-1:0] key_ff, key_in;
   logic [31:0]          time_ff, time_in;
   logic [31:0]          size_ff, size_in;
   rsp_type              result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // Derived values
   logic [CW-1:0]          mid;
   logic [CW-1:0]          count_inc;
   logic [CW-1:0]          shift_dec;
   logic [NAME_BITS+15:0]  name_ext;
   logic [CW+7:0]          pos_ext;
   logic [CW+8:0]          count_ext;
   logic [CW+8:0]          count_inc_ext;
   logic [NAME_BITS-1:0]   rd_name;
   logic [31:0]            rd_time;
   logic [31:0]            rd_size;
   logic [15:0]            rd_uses;
   logic [15:0]            uses_inc;
   logic                   name_hit;
   logic                   full_hit;
   logic                   out_free;

   assign mid           = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign count_inc     = count_ff + CW'(1);
   assign shift_dec     = shift_ff - CW'(1);
   assign name_ext      = {{NAME_BITS{1'b0}}, req_data.name_id};
   assign pos_ext       = {8'd0, pos_ff};
   assign count_ext     = {9'd0, count_ff};
   assign count_inc_ext = {9'd0, count_inc};
   assign rd_name       = rd_data_ff[NAM_LSB +: NAME_BITS];
   assign rd_time       = rd_data_ff[TIM_LSB +: 32];
   assign rd_size       = rd_data_ff[SIZ_LSB +: 32];
   assign rd_uses       = rd_data_ff[USE_LSB +: 16];
   assign uses_inc      = (rd_uses == USE_MAX) ? rd_uses : rd_uses + 16'd1;
   assign name_hit      = (rd_name == key_ff);
   assign full_hit      = name_hit && (rd_time == time_ff) && (rd_size == size_ff);
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // Write and read the record memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= rec_mem[mem_raddr];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? ST_SEARCH_CMP : ST_SCAN;
         end
         ST_SEARCH_CMP: begin
            state_in = ST_SEARCH;
         end
         ST_SCAN: begin
            state_in = (pos_ff < count_ff) ? ST_SCAN_CMP : ST_PLACE;
         end
         ST_SCAN_CMP: begin
            if (!name_hit) begin
               state_in = ST_PLACE;
            end else if (full_hit) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_PLACE: begin
            if (count_ff >= DEPTH_CNT) begin
               state_in = ST_FINISH;
            end else if (shift_ff > pos_ff) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_RD: begin
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            state_in = ST_PLACE;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control and memory access per state
   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      shift_in     = shift_ff;
      key_in       = key_ff;
      time_in      = time_ff;
      size_in      = size_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[IW-1:0];
      mem_wdata    = rd_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = mid[IW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            // Capture the transaction and open the search window
            if (req_valid) begin
               key_in   = name_ext[NAME_BITS-1:0];
               time_in  = req_data.mod_time;
               size_in  = req_data.file_size;
               lo_in    = '0;
               hi_in    = count_ff;
               shift_in = count_ff;
            end
         end
         ST_SEARCH: begin
            // Probe the middle record, or hand the lower bound to the scan
            if (lo_ff < hi_ff) begin
               mem_re    = 1'b1;
               mem_raddr = mid[IW-1:0];
            end else begin
               pos_in = lo_ff;
            end
         end
         ST_SEARCH_CMP: begin
            // Narrow the window
            if (rd_name < key_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
         end
         ST_SCAN: begin
            if (pos_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = pos_ff[IW-1:0];
            end
         end
         ST_SCAN_CMP: begin
            // On a duplicate bump its use count and report it; on a name-only match advance
            if (full_hit) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[IW-1:0];
               mem_wdata = {rd_data_ff[REC_W-1:SIZ_LSB], uses_inc};
               result_in.entry_position = pos_ext[7:0];
               result_in.was_inserted   = 1'b0;
               result_in.table_full     = 1'b0;
               result_in.entry_count    = count_ext[8:0];
               result_in.use_count      = uses_inc;
            end else if (name_hit) begin
               pos_in = pos_ff + CW'(1);
            end
         end
         ST_PLACE: begin
            if (count_ff >= DEPTH_CNT) begin
               // Refuse the insert
               result_in.entry_position = '0;
               result_in.was_inserted   = 1'b0;
               result_in.table_full     = 1'b1;
               result_in.entry_count    = count_ext[8:0];
               result_in.use_count      = '0;
            end else if (shift_ff <= pos_ff) begin
               // Gap is open: store the new record
               mem_we    = 1'b1;
               mem_waddr = pos_ff[IW-1:0];
               mem_wdata = {key_ff, time_ff, size_ff, 16'd1};
               count_in  = count_inc;
               result_in.entry_position = pos_ext[7:0];
               result_in.was_inserted   = 1'b1;
               result_in.table_full     = 1'b0;
               result_in.entry_count    = count_inc_ext[8:0];
               result_in.use_count      = 16'd1;
            end
         end
         ST_SHIFT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = shift_dec[IW-1:0];
         end
         ST_SHIFT_WR: begin
            // Move one record up
            mem_we    = 1'b1;
            mem_waddr = shift_ff[IW-1:0];
            mem_wdata = rd_data_ff;
            shift_in  = shift_dec;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      pos_ff      <= pos_in;
      shift_ff    <= shift_in;
      key_ff      <= key_in;
      time_ff     <= time_in;
      size_ff     <= size_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/stdi_checker.sv -----
// Port-level checker for the sorted table dedup/insert unit, bound to it.
// Depends on stdi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stdi_checker
   import stdi_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Classify the response on the channel
   logic ins_rsp;
   logic full_rsp;
   logic hit_rsp;
   logic ins_ok;
   logic full_ok;

   assign ins_rsp  = rsp_valid && rsp_data.was_inserted;
   assign full_rsp = rsp_valid && rsp_data.table_full;
   assign hit_rsp  = rsp_valid && !rsp_data.was_inserted && !rsp_data.table_full;
   assign ins_ok   = (rsp_data.use_count == 16'd1) && (rsp_data.entry_count != 9'd0);
   assign full_ok  = (rsp_data.use_count == 16'd0) && (rsp_data.entry_position == 8'd0);

   // Hold a stalled result
   `STDI_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Insert and refusal never come together
   `STDI_ASSERT_IMP(a_ins_xor_full, clock, reset, ins_rsp, !rsp_data.table_full)

   // A new record starts with one use
   `STDI_ASSERT_IMP(a_ins_uses, clock, reset, ins_rsp, ins_ok)

   // A refused insert reports an empty record
   `STDI_ASSERT_IMP(a_full_empty, clock, reset, full_rsp, full_ok)

   // A matched record has been used before
   `STDI_ASSERT_IMP(a_match_uses, clock, reset, hit_rsp, rsp_data.use_count >= 16'd2)

endmodule

bind sorted_table_dedup_insert_unit stdi_checker u_stdi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
